[hdl/priority_round_robin_task_scheduler_top_defines.svh]
// assertion macros for the task scheduler
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define PRRTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define PRRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/prrts_pkg.sv]
// ----------------------------------------------------------------------------
// prrts_pkg
// Shared constants, codes and types of the priority round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package prrts_pkg;

    localparam int MAX_TASKS       = 8;
    localparam int PRIORITY_LEVELS = 4;
    localparam int NSLOTS          = MAX_TASKS + 1;
    localparam int NLEVELS         = PRIORITY_LEVELS + 1;

    localparam int SLOT_W = 4;
    localparam int PRIO_W = $clog2(NLEVELS);
    localparam int LVL_W  = $clog2(NLEVELS + 1);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int DIDX_W = $clog2(MAX_TASKS);
    localparam int DATA_W = 32;

    localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(MAX_TASKS);
    localparam logic [SLOT_W-1:0] NO_SLOT   = '1;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_START  = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_DELAY  = 3'd3,
        CMD_YIELD  = 3'd4,
        CMD_SWITCH = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_DELAY_ERR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RS_READY   = 2'd0,
        RS_RUNNING = 2'd1,
        RS_BLOCKED = 2'd2
    } t_run;

    typedef enum logic {
        MODE_NORMAL     = 1'b0,
        MODE_FROM_RESET = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_TICK_RD,
        CS_TICK_WR,
        CS_SCHED_GO,
        CS_SCHED_WAIT,
        CS_SW_RD,
        CS_SW_DATA,
        CS_DONE
    } t_ctl_st;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_LVL,
        SC_WALK
    } t_sch_st;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] next;
    } t_sched_res;

endpackage

`default_nettype wire

[hdl/prrts_ram.sv]
// ----------------------------------------------------------------------------
// prrts_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prrts_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/prrts_sched.sv]
// ----------------------------------------------------------------------------
// prrts_sched
// Ring walker: scans the levels from the highest priority and steps through
// one slot of a level's ring per cycle, keeping the round-robin pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module prrts_sched import prrts_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire logic              i_init,
    input  wire logic              i_valid [NSLOTS],
    input  wire logic [PRIO_W-1:0] i_prio [NSLOTS],
    input  t_run                   i_state [NSLOTS],
    input  wire logic [CNT_W-1:0]  i_lcount [NLEVELS],
    output t_sched_res             o_res
);

    t_sch_st           r_st, n_st;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [SLOT_W-1:0] r_p, n_p;
    logic [CNT_W-1:0]  r_k, n_k;
    logic              r_run, n_run;
    logic [SLOT_W-1:0] r_rr [NLEVELS];
    logic [SLOT_W-1:0] n_rr [NLEVELS];

    logic [CNT_W-1:0]  cnt;
    logic [PRIO_W-1:0] lv;
    logic [SLOT_W-1:0] ptr;

    function automatic logic in_level(input logic [SLOT_W-1:0] s, input logic [PRIO_W-1:0] l);
        logic r;
        r = 1'b0;
        if (s < SLOT_W'(NSLOTS)) begin
            r = i_valid[s] && (i_prio[s] == l);
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] first_of(input logic [PRIO_W-1:0] l);
        logic [SLOT_W-1:0] r;
        r = NO_SLOT;
        for (int i = NSLOTS - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_prio[i] == l)) begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    // smallest member above s, else wrap to the first member
    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s,
                                                    input logic [PRIO_W-1:0] l);
        logic [SLOT_W-1:0] r;
        r = first_of(l);
        for (int i = NSLOTS - 1; i >= 0; i--) begin
            if ((SLOT_W'(i) > s) && i_valid[i] && (i_prio[i] == l)) begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    assign lv  = r_lvl[PRIO_W-1:0];
    assign cnt = (r_lvl < LVL_W'(NLEVELS)) ? i_lcount[lv] : '0;
    assign ptr = (r_lvl < LVL_W'(NLEVELS)) ? r_rr[lv] : NO_SLOT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= SC_IDLE;
            r_lvl <= '0;
            r_p   <= NO_SLOT;
            r_k   <= '0;
            r_run <= 1'b0;
            for (int l = 0; l < NLEVELS; l++) begin
                r_rr[l] <= NO_SLOT;
            end
        end else begin
            r_st  <= n_st;
            r_lvl <= n_lvl;
            r_p   <= n_p;
            r_k   <= n_k;
            r_run <= n_run;
            r_rr  <= n_rr;
        end
    end

    always_comb begin
        n_st  = r_st;
        n_lvl = r_lvl;
        n_p   = r_p;
        n_k   = r_k;
        n_run = r_run;
        n_rr  = r_rr;
        o_res = '0;
        unique case (r_st)
            SC_IDLE: begin
                if (i_go) begin
                    n_lvl = '0;
                    n_st  = SC_LVL;
                end
            end
            SC_LVL: begin
                if (r_lvl == LVL_W'(NLEVELS)) begin
                    o_res.done = 1'b1;
                    n_st       = SC_IDLE;
                end else if (cnt == '0) begin
                    n_lvl = r_lvl + 1'b1;
                end else begin
                    // stale or empty pointer restarts at the level's first task
                    n_p   = in_level(ptr, lv) ? ptr : first_of(lv);
                    n_k   = '0;
                    n_run = 1'b0;
                    n_st  = SC_WALK;
                end
            end
            SC_WALK: begin
                if ((r_k < cnt) && (r_p < SLOT_W'(NSLOTS))) begin
                    if (i_state[r_p] == RS_RUNNING) begin
                        n_run = 1'b1;
                    end
                    if (i_state[r_p] == RS_READY) begin
                        o_res.done  = 1'b1;
                        o_res.found = 1'b1;
                        o_res.next  = r_p;
                        n_rr[lv]    = r_p;
                        n_st        = SC_IDLE;
                    end else begin
                        n_p = ring_next(r_p, lv);
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    n_rr[lv] = r_p;
                    if (r_run) begin
                        o_res.done = 1'b1;
                        n_st       = SC_IDLE;
                    end else begin
                        n_lvl = r_lvl + 1'b1;
                        n_st  = SC_LVL;
                    end
                end
            end
            default: begin
                n_st = SC_IDLE;
            end
        endcase
        if (i_init) begin
            for (int l = 0; l < NLEVELS; l++) begin
                n_rr[l] = (l == NLEVELS - 1) ? IDLE_SLOT : first_of(PRIO_W'(l));
            end
        end
    end

endmodule

`default_nettype wire

[hdl/priority_round_robin_task_scheduler_top.sv]
// Task scheduler with 8 task slots plus an idle slot over 4 priority levels. One item
// is in work at a time. Create, start, a zero-length or rejected delay and unknown
// commands go straight to the result; a context switch passes through the write, the
// read and the registered read data of the stack-pointer ram. Scheduling (yield, delay,
// tick) runs the ring walker, which looks at the levels in turn and at the slots of each
// ring. A tick first sweeps the delay ram, passing over empty slots and reading, then
// writing back, each created slot. A finished result waits in the output register while
// the next item is taken.
`default_nettype none

`include "priority_round_robin_task_scheduler_top_defines.svh"

// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top
// Command sequencer, slot control table, delay ram and stack-pointer ram.
// ----------------------------------------------------------------------------
module priority_round_robin_task_scheduler_top import prrts_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [2:0]          i_cmd,
    input  wire logic [1:0]          i_priority_req,
    input  wire logic [DATA_W-1:0]   i_ticks,
    input  wire logic [DATA_W-1:0]   i_stack_pointer,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_status,
    output logic [SLOT_W-1:0]        o_task_id,
    output logic                     o_switch_pending,
    output logic [DATA_W-1:0]        o_resume_pointer
);

    t_ctl_st           r_st, n_st;
    logic              r_valid [NSLOTS];
    logic              n_valid [NSLOTS];
    logic [PRIO_W-1:0] r_prio [NSLOTS];
    logic [PRIO_W-1:0] n_prio [NSLOTS];
    t_run              r_state [NSLOTS];
    t_run              n_state [NSLOTS];
    logic [CNT_W-1:0]  r_lcount [NLEVELS];
    logic [CNT_W-1:0]  n_lcount [NLEVELS];
    logic [CNT_W-1:0]  r_total, n_total;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_next, n_next;
    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_idx, n_idx;

    t_status           r_res_status, n_res_status;
    logic [SLOT_W-1:0] r_res_id, n_res_id;
    logic              r_res_pend, n_res_pend;
    logic [DATA_W-1:0] r_res_resume, n_res_resume;

    logic              r_ovalid, n_ovalid;
    t_status           r_o_status, n_o_status;
    logic [SLOT_W-1:0] r_o_id, n_o_id;
    logic              r_o_pend, n_o_pend;
    logic [DATA_W-1:0] r_o_resume, n_o_resume;

    logic              accept;
    logic [PRIO_W-1:0] cprio;
    logic              sched_go;
    logic              sched_init;
    t_sched_res        sched_res;

    logic              dly_we;
    logic [DIDX_W-1:0] dly_waddr;
    logic [DATA_W:0]   dly_wdata;
    logic [DIDX_W-1:0] dly_raddr;
    logic [DATA_W:0]   dly_rdata;
    logic [DATA_W-1:0] dly_cnt;

    logic              sp_we;
    logic [SLOT_W-1:0] sp_waddr;
    logic [SLOT_W-1:0] sp_raddr;
    logic [DATA_W-1:0] sp_rdata;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_st != CS_IDLE);
    assign cprio      = (i_priority_req > 2'(PRIORITY_LEVELS - 1)) ?
                        PRIO_W'(PRIORITY_LEVELS - 1) : PRIO_W'(i_priority_req);
    assign dly_cnt    = (dly_rdata[DATA_W-1:0] != '0) ? (dly_rdata[DATA_W-1:0] - 1'b1) : '0;

    // delay ram: {active, count} per task slot
    prrts_ram #(.DEPTH(MAX_TASKS), .WIDTH(DATA_W + 1)) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (dly_waddr),
        .i_wdata (dly_wdata),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

    prrts_ram #(.DEPTH(NSLOTS), .WIDTH(DATA_W)) u_sp_ram (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (i_stack_pointer),
        .i_raddr (sp_raddr),
        .o_rdata (sp_rdata)
    );

    prrts_sched u_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (sched_go),
        .i_init   (sched_init),
        .i_valid  (r_valid),
        .i_prio   (r_prio),
        .i_state  (r_state),
        .i_lcount (r_lcount),
        .o_res    (sched_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= CS_IDLE;
            for (int i = 0; i < NSLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_prio[i]  <= '0;
                r_state[i] <= RS_READY;
            end
            for (int l = 0; l < NLEVELS; l++) begin
                r_lcount[l] <= '0;
            end
            r_total  <= '0;
            r_cur    <= NO_SLOT;
            r_next   <= NO_SLOT;
            r_mode   <= MODE_NORMAL;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_valid  <= n_valid;
            r_prio   <= n_prio;
            r_state  <= n_state;
            r_lcount <= n_lcount;
            r_total  <= n_total;
            r_cur    <= n_cur;
            r_next   <= n_next;
            r_mode   <= n_mode;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_pend   <= n_res_pend;
        r_res_resume <= n_res_resume;
        r_o_status   <= n_o_status;
        r_o_id       <= n_o_id;
        r_o_pend     <= n_o_pend;
        r_o_resume   <= n_o_resume;
    end

    always_comb begin
        n_st         = r_st;
        n_valid      = r_valid;
        n_prio       = r_prio;
        n_state      = r_state;
        n_lcount     = r_lcount;
        n_total      = r_total;
        n_cur        = r_cur;
        n_next       = r_next;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_pend   = r_res_pend;
        n_res_resume = r_res_resume;
        n_ovalid     = r_ovalid && i_out_stall;
        n_o_status   = r_o_status;
        n_o_id       = r_o_id;
        n_o_pend     = r_o_pend;
        n_o_resume   = r_o_resume;
        sched_go     = 1'b0;
        sched_init   = 1'b0;
        dly_we       = 1'b0;
        dly_waddr    = r_idx[DIDX_W-1:0];
        dly_wdata    = dly_rdata;
        dly_raddr    = r_idx[DIDX_W-1:0];
        sp_we        = 1'b0;
        sp_waddr     = r_cur;
        sp_raddr     = r_cur;

        unique case (r_st)
            CS_IDLE: begin
                if (accept) begin
                    n_res_status = STS_OK;
                    n_res_id     = '0;
                    n_res_pend   = 1'b0;
                    n_res_resume = '0;
                    n_st         = CS_DONE;
                    unique case (t_cmd'(i_cmd))
                        CMD_CREATE: begin
                            if (r_total >= CNT_W'(MAX_TASKS)) begin
                                n_res_status = STS_FULL;
                            end else begin
                                n_valid[r_total]  = 1'b1;
                                n_prio[r_total]   = cprio;
                                n_state[r_total]  = RS_READY;
                                n_lcount[cprio]   = r_lcount[cprio] + 1'b1;
                                n_total           = r_total + 1'b1;
                                n_res_id          = SLOT_W'(r_total);
                                dly_we            = 1'b1;
                                dly_waddr         = r_total[DIDX_W-1:0];
                                dly_wdata         = '0;
                            end
                        end
                        CMD_START: begin
                            n_valid[IDLE_SLOT]  = 1'b1;
                            n_prio[IDLE_SLOT]   = PRIO_W'(PRIORITY_LEVELS);
                            n_state[IDLE_SLOT]  = RS_READY;
                            n_lcount[NLEVELS-1] = CNT_W'(1);
                            n_mode              = MODE_FROM_RESET;
                            n_cur               = NO_SLOT;
                            n_next              = NO_SLOT;
                            sched_init          = 1'b1;
                        end
                        CMD_TICK: begin
                            n_idx = '0;
                            n_st  = CS_TICK_RD;
                        end
                        CMD_DELAY: begin
                            if (i_ticks == '0) begin
                                n_st = CS_DONE;
                            end else if (r_cur >= IDLE_SLOT) begin
                                n_res_status = STS_DELAY_ERR;
                            end else begin
                                dly_we         = 1'b1;
                                dly_waddr      = r_cur[DIDX_W-1:0];
                                dly_wdata      = {1'b1, i_ticks};
                                n_state[r_cur] = RS_BLOCKED;
                                n_st           = CS_SCHED_GO;
                            end
                        end
                        CMD_YIELD: begin
                            n_st = CS_SCHED_GO;
                        end
                        CMD_SWITCH: begin
                            if (r_next != NO_SLOT) begin
                                if (r_cur < SLOT_W'(NSLOTS)) begin
                                    sp_we = 1'b1;
                                    if (r_state[r_cur] == RS_RUNNING) begin
                                        n_state[r_cur] = RS_READY;
                                    end
                                end
                                n_cur           = r_next;
                                n_state[r_next] = RS_RUNNING;
                                n_mode          = MODE_NORMAL;
                                n_st            = CS_SW_RD;
                            end
                        end
                        default: begin
                            n_st = CS_DONE;
                        end
                    endcase
                end
            end
            CS_TICK_RD: begin
                if (r_idx == CNT_W'(MAX_TASKS)) begin
                    n_st = CS_SCHED_GO;
                end else if (!r_valid[r_idx]) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_st = CS_TICK_WR;
                end
            end
            CS_TICK_WR: begin
                // count down, and wake a blocked task whose count reached zero
                if (dly_rdata[DATA_W]) begin
                    dly_we    = 1'b1;
                    dly_wdata = {1'b1, dly_cnt};
                    if ((r_state[r_idx] == RS_BLOCKED) && (dly_cnt == '0)) begin
                        n_state[r_idx] = RS_READY;
                        dly_wdata      = {1'b0, dly_cnt};
                    end
                end
                n_idx = r_idx + 1'b1;
                n_st  = CS_TICK_RD;
            end
            CS_SCHED_GO: begin
                if (r_mode == MODE_FROM_RESET) begin
                    n_cur  = IDLE_SLOT;
                    n_mode = MODE_NORMAL;
                end
                sched_go = 1'b1;
                n_st     = CS_SCHED_WAIT;
            end
            CS_SCHED_WAIT: begin
                if (sched_res.done) begin
                    n_res_pend = sched_res.found;
                    if (sched_res.found) begin
                        n_next = sched_res.next;
                    end
                    n_st = CS_DONE;
                end
            end
            CS_SW_RD: begin
                n_st = CS_SW_DATA;
            end
            CS_SW_DATA: begin
                n_res_id     = r_cur;
                n_res_resume = sp_rdata;
                n_st         = CS_DONE;
            end
            CS_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_res_status;
                    n_o_id     = r_res_id;
                    n_o_pend   = r_res_pend;
                    n_o_resume = r_res_resume;
                    n_st       = CS_IDLE;
                end
            end
            default: begin
                n_st = CS_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_o_status;
    assign o_task_id        = r_o_id;
    assign o_switch_pending = r_o_pend;
    assign o_resume_pointer = r_o_resume;

    `PRRTS_ASSERT_NEXT(a_busy_after_accept, accept, o_in_stall, "no busy after accepted item")
    `PRRTS_ASSERT_NOW(a_total_bound, 1'b1, r_total <= CNT_W'(MAX_TASKS), "task total overflow")
    `PRRTS_ASSERT_NOW(a_pend_ok, o_out_valid && o_switch_pending, o_status == STS_OK,
                      "switch request with error status")
    `PRRTS_ASSERT_NOW(a_cur_range, 1'b1, (r_cur == NO_SLOT) || (r_cur < SLOT_W'(NSLOTS)),
                      "current slot out of range")

endmodule

`default_nettype wire
